[hw/rtl/byte_entropy_lsb_stego_analyzer_unit_assert.svh]
// Assertion macros for the byte entropy analyzer.
`ifndef BYTE_ENTROPY_LSB_STEGO_ANALYZER_UNIT_ASSERT_SVH
`define BYTE_ENTROPY_LSB_STEGO_ANALYZER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BSA_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define BSA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define BSA_ASSERT(name, prop)
`define BSA_ASSERT_IMP(name, ante, cons)
`endif
`endif

[hw/rtl/bsa_pkg.sv]
// Types, constants and log2 helpers for the byte entropy analyzer.
`default_nettype none
package bsa_pkg;
    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_BINS   = 256;
    localparam int BIN_AW     = 8;
    localparam int LOG_W      = 22;
    localparam int ACC_W      = 54;
    localparam int NUM_W      = 72;
    localparam int DATA_W     = 128;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [39:0] CHI_MAX = 40'hFFFFFFFF00;
    localparam logic [NUM_W-1:0] ENT_MAX = NUM_W'(8) << FRAC_BITS;
    localparam logic [16:0] ONE  = 17'h10000;
    localparam logic [16:0] HALF = 17'h08000;
    localparam logic [16:0] HIGH_TH = 17'h0C000;

    localparam logic [1:0] ASSESS_LOW  = 2'd0;
    localparam logic [1:0] ASSESS_MOD  = 2'd1;
    localparam logic [1:0] ASSESS_HIGH = 2'd2;

    localparam logic [16:0] LOG_TAB [17] = '{
        17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
        17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
        17'd56229, 17'd59434, 17'd62534, 17'd65536
    };

    typedef struct packed {
        logic [4:0]  e;
        logic [16:0] tk;
        logic [12:0] step;
        logic [15:0] r;
    } t_lg_front;

    typedef struct packed {
        logic start;
    } t_walk_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_walk_sts;

    function automatic t_lg_front log2_front(input logic [COUNT_BITS-1:0] x);
        t_lg_front   res;
        logic [4:0]  e;
        logic [31:0] norm;
        logic [3:0]  k;
        logic [16:0] t1;
        e = 5'd0;
        for (int i = 0; i < COUNT_BITS; i++) begin
            if (x[i]) e = 5'(i);
        end
        norm = x << (5'd31 - e);
        k = norm[30:27];
        t1 = LOG_TAB[5'({1'b0, k}) + 5'd1];
        res.e = e;
        res.tk = LOG_TAB[k];
        res.step = 13'(t1 - LOG_TAB[k]);
        res.r = norm[26:11];
        return res;
    endfunction

    function automatic logic [LOG_W-1:0] log2_back(input t_lg_front f);
        logic [28:0] prod;
        prod = 29'(f.step) * 29'(f.r);
        return LOG_W'({f.e, 16'h0}) + LOG_W'(f.tk) + LOG_W'(prod[28:16]);
    endfunction
endpackage
`default_nettype wire

[hw/rtl/bsa_ram.sv]
// Generic single-write, single-read RAM with registered read.
`default_nettype none
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/bsa_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module bsa_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bsa_pkg::NUM_W-1:0]  i_num,
    input  wire logic [bsa_pkg::COUNT_BITS-1:0] i_den,
    output logic                            o_busy,
    output logic                            o_done,
    output logic      [bsa_pkg::NUM_W-1:0]  o_quo
);
    logic                              r_busy;
    logic                              r_done;
    logic [6:0]                        r_cnt;
    logic [bsa_pkg::NUM_W-1:0]         r_num;
    logic [bsa_pkg::NUM_W-1:0]         r_quo;
    logic [bsa_pkg::COUNT_BITS-1:0]    r_rem;
    logic [bsa_pkg::COUNT_BITS-1:0]    r_den;
    logic [bsa_pkg::COUNT_BITS:0]      rem_sh;
    logic                              ge;
    logic [bsa_pkg::COUNT_BITS:0]      rem_sub;

    assign rem_sh  = {r_rem, r_num[bsa_pkg::NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(bsa_pkg::NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[bsa_pkg::NUM_W-2:0], 1'b0};
            r_rem <= ge ? rem_sub[bsa_pkg::COUNT_BITS-1:0] : rem_sh[bsa_pkg::COUNT_BITS-1:0];
            r_quo <= {r_quo[bsa_pkg::NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

[hw/rtl/bsa_walk.sv]
// Histogram memory: per-byte read-modify-write and the bin walk with entropy sum.
`default_nettype none
module bsa_walk (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_byte_vld,
    input  wire logic [bsa_pkg::BIN_AW-1:0]      i_byte_val,
    input  wire bsa_pkg::t_walk_ctl              i_ctl,
    input  wire logic [bsa_pkg::LOG_W-1:0]       i_ln,
    output bsa_pkg::t_walk_sts                   o_sts,
    output logic      [bsa_pkg::ACC_W-1:0]       o_acc
);
    logic                               r_busy;
    logic                               r_issue;
    logic                               r_done;
    logic [bsa_pkg::BIN_AW-1:0]         r_idx;
    logic                               r_s1_vld;
    logic                               r_s1_inc;
    logic [bsa_pkg::BIN_AW-1:0]         r_s1_addr;
    logic                               r_wb_vld;
    logic [bsa_pkg::BIN_AW-1:0]         r_wb_addr;
    logic [bsa_pkg::COUNT_BITS-1:0]     r_wb_data;
    logic                               r_s2_vld;
    logic [bsa_pkg::COUNT_BITS-1:0]     r_s2_h;
    bsa_pkg::t_lg_front                 r_s2_lf;
    logic                               r_s3_vld;
    logic [bsa_pkg::COUNT_BITS-1:0]     r_s3_h;
    logic [bsa_pkg::LOG_W-1:0]          r_s3_lh;
    logic                               r_s4_vld;
    logic [bsa_pkg::ACC_W-1:0]          r_s4_prod;
    logic [bsa_pkg::ACC_W-1:0]          r_acc;
    logic [bsa_pkg::BIN_AW-1:0]         raddr;
    logic [bsa_pkg::COUNT_BITS-1:0]     rdata;
    logic [bsa_pkg::COUNT_BITS-1:0]     cur;
    logic [bsa_pkg::COUNT_BITS-1:0]     wdata;
    logic [bsa_pkg::LOG_W-1:0]          d;

    assign raddr = r_issue ? r_idx : i_byte_val;
    assign cur   = (r_wb_vld && r_wb_addr == r_s1_addr) ? r_wb_data : rdata;
    assign wdata = !r_s1_inc ? '0 :
                   (cur == bsa_pkg::CNT_MAX) ? cur : cur + 1'b1;
    assign d     = (i_ln > r_s3_lh) ? i_ln - r_s3_lh : '0;

    bsa_ram #(.WIDTH(bsa_pkg::COUNT_BITS), .DEPTH(bsa_pkg::NUM_BINS)) u_hist (
        .i_clk  (i_clk),
        .i_we   (r_s1_vld),
        .i_waddr(r_s1_addr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_issue  <= 1'b0;
            r_done   <= 1'b0;
            r_idx    <= '0;
            r_s1_vld <= 1'b0;
            r_wb_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_s1_vld <= r_issue || i_byte_vld;
            r_wb_vld <= r_s1_vld;
            r_s2_vld <= r_s1_vld && !r_s1_inc;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            if (i_ctl.start && !r_busy) begin
                r_busy  <= 1'b1;
                r_issue <= 1'b1;
                r_idx   <= '0;
            end else if (r_issue) begin
                if (r_idx == bsa_pkg::BIN_AW'(bsa_pkg::NUM_BINS - 1)) r_issue <= 1'b0;
                r_idx <= r_idx + 1'b1;
            end else if (r_busy && !r_s1_vld && !r_s2_vld && !r_s3_vld && !r_s4_vld) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_inc  <= !r_issue;
        r_s1_addr <= raddr;
        r_wb_addr <= r_s1_addr;
        r_wb_data <= wdata;
        r_s2_h    <= cur;
        r_s2_lf   <= bsa_pkg::log2_front(cur);
        r_s3_h    <= r_s2_h;
        r_s3_lh   <= bsa_pkg::log2_back(r_s2_lf);
        r_s4_prod <= bsa_pkg::ACC_W'(r_s3_h) * bsa_pkg::ACC_W'(d);
        if (i_ctl.start && !r_busy) r_acc <= '0;
        else if (r_s4_vld) r_acc <= r_acc + r_s4_prod;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_acc      = r_acc;
endmodule
`default_nettype wire

[hw/rtl/byte_entropy_lsb_stego_analyzer_unit.sv]
// A data byte gives no word; one byte is accepted per cycle while idle with no word pending.
// A finish gives its word after a 256-bin walk of the histogram RAM through its pipeline
// plus three serial divisions (entropy, ones fraction, chi-square); an empty stream
// gives its word without the walk or the divisions.
// Reset (synchronous, active low) starts a clearing pass over all 256 bins of the histogram
// RAM; the input opens when that pass has finished.
`default_nettype none
`include "byte_entropy_lsb_stego_analyzer_unit_assert.svh"
module byte_entropy_lsb_stego_analyzer_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // byte_value
    input  wire logic [0:0]   s_tuser,   // req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // entropy_bits, ones_fraction, lsb_chi, suspicion_score, byte_total, assessment
    output logic      [127:0] m_tdata,
    output logic      [0:0]   m_tuser    // status
);
    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_INITW = 3'd1;
    localparam logic [2:0] ST_IDLE  = 3'd2;
    localparam logic [2:0] ST_WGO   = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_DIVE  = 3'd5;
    localparam logic [2:0] ST_DIVP  = 3'd6;
    localparam logic [2:0] ST_DIVC  = 3'd7;

    logic [2:0]                          r_state;
    logic                                r_out_pend;
    logic                                r_empty;
    logic [bsa_pkg::COUNT_BITS-1:0]      r_cnt;
    logic [bsa_pkg::COUNT_BITS-1:0]      r_odd;
    logic [bsa_pkg::COUNT_BITS-1:0]      r_d;
    logic [63:0]                         r_dd;
    bsa_pkg::t_lg_front                  r_ln_f;
    logic [bsa_pkg::LOG_W-1:0]           r_ln;
    logic [19:0]                         r_ent;
    logic [16:0]                         r_p1;
    logic [39:0]                         r_chi;
    logic                                r_m_vld;
    logic [127:0]                        r_m_data;
    logic                                r_m_user;
    logic [2:0]                          n_state;
    bsa_pkg::t_walk_ctl                  walk_ctl;
    bsa_pkg::t_walk_sts                  walk_sts;
    logic [bsa_pkg::ACC_W-1:0]           acc;
    logic                                div_start;
    logic [bsa_pkg::NUM_W-1:0]           div_num;
    logic                                div_busy;
    logic                                div_done;
    logic [bsa_pkg::NUM_W-1:0]           quo;
    logic                                s_acc;
    logic                                byte_acc;
    logic                                fin_acc;
    logic                                out_load;
    logic [bsa_pkg::COUNT_BITS:0]        twice;
    logic [16:0]                         bias;
    logic [18:0]                         b4;
    logic [16:0]                         lsb_s;
    logic [16:0]                         ent_s;
    logic [17:0]                         sum_s;
    logic [16:0]                         score;
    logic [1:0]                          assess;

    assign s_tready = r_state == ST_IDLE && !r_out_pend;
    assign s_acc    = s_tvalid && s_tready;
    assign byte_acc = s_acc && !s_tuser[0];
    assign fin_acc  = s_acc && s_tuser[0];
    assign out_load = r_out_pend && (!r_m_vld || m_tready);
    assign twice    = {r_odd, 1'b0};

    assign walk_ctl.start = r_state == ST_INIT || r_state == ST_WGO;

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        if (r_state == ST_WALK && walk_sts.done) begin
            div_start = 1'b1;
            div_num   = bsa_pkg::NUM_W'(acc);
        end else if (r_state == ST_DIVE && div_done) begin
            div_start = 1'b1;
            div_num   = bsa_pkg::NUM_W'({r_odd, 16'h0});
        end else if (r_state == ST_DIVP && div_done) begin
            div_start = 1'b1;
            div_num   = {r_dd, 8'h0};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT:  n_state = ST_INITW;
            ST_INITW: if (walk_sts.done) n_state = ST_IDLE;
            ST_IDLE:  if (fin_acc && r_cnt != '0) n_state = ST_WGO;
            ST_WGO:   n_state = ST_WALK;
            ST_WALK:  if (walk_sts.done) n_state = ST_DIVE;
            ST_DIVE:  if (div_done) n_state = ST_DIVP;
            ST_DIVP:  if (div_done) n_state = ST_DIVC;
            ST_DIVC:  if (div_done) n_state = ST_IDLE;
            default:  n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_out_pend <= 1'b0;
            r_cnt      <= '0;
            r_odd      <= '0;
            r_m_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_tready) r_m_vld <= 1'b0;
            if (out_load) begin
                r_m_vld    <= 1'b1;
                r_out_pend <= 1'b0;
                r_cnt      <= '0;
                r_odd      <= '0;
            end else if ((fin_acc && r_cnt == '0) || (r_state == ST_DIVC && div_done)) begin
                r_out_pend <= 1'b1;
            end
            if (byte_acc) begin
                if (r_cnt != bsa_pkg::CNT_MAX) r_cnt <= r_cnt + 1'b1;
                if (s_tdata[0] && r_odd != bsa_pkg::CNT_MAX) r_odd <= r_odd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d    <= ({1'b0, r_cnt} >= twice) ? 32'({1'b0, r_cnt} - twice)
                                           : 32'(twice - {1'b0, r_cnt});
        r_dd   <= 64'(r_d) * 64'(r_d);
        r_ln_f <= bsa_pkg::log2_front(r_cnt);
        r_ln   <= bsa_pkg::log2_back(r_ln_f);
        if (fin_acc) r_empty <= r_cnt == '0;
        if (r_state == ST_DIVE && div_done)
            r_ent <= (quo > bsa_pkg::ENT_MAX) ? 20'(bsa_pkg::ENT_MAX) : quo[19:0];
        if (r_state == ST_DIVP && div_done) r_p1 <= quo[16:0];
        if (r_state == ST_DIVC && div_done)
            r_chi <= (quo > bsa_pkg::NUM_W'(bsa_pkg::CHI_MAX)) ? bsa_pkg::CHI_MAX : quo[39:0];
        if (out_load) begin
            r_m_user <= r_empty;
            r_m_data <= r_empty ? '0 : {assess, r_cnt, score, r_chi, r_p1, r_ent};
        end
    end

    always_comb begin
        bias  = (r_p1 >= bsa_pkg::HALF) ? r_p1 - bsa_pkg::HALF : bsa_pkg::HALF - r_p1;
        b4    = {bias, 2'b00};
        lsb_s = (b4 > 19'(bsa_pkg::ONE)) ? 17'd0 : 17'(19'(bsa_pkg::ONE) - b4);
        ent_s = (r_ent[19:3] > bsa_pkg::ONE) ? bsa_pkg::ONE : r_ent[19:3];
        sum_s = 18'(lsb_s) + 18'(ent_s);
        score = sum_s[17:1];
        if (score >= bsa_pkg::HIGH_TH)   assess = bsa_pkg::ASSESS_HIGH;
        else if (score >= bsa_pkg::HALF) assess = bsa_pkg::ASSESS_MOD;
        else                             assess = bsa_pkg::ASSESS_LOW;
    end

    bsa_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_vld(byte_acc),
        .i_byte_val(s_tdata),
        .i_ctl     (walk_ctl),
        .i_ln      (r_ln),
        .o_sts     (walk_sts),
        .o_acc     (acc)
    );

    bsa_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (r_cnt),
        .o_busy (div_busy),
        .o_done (div_done),
        .o_quo  (quo)
    );

    assign m_tvalid   = r_m_vld;
    assign m_tdata    = r_m_data;
    assign m_tuser[0] = r_m_user;

    `BSA_ASSERT_IMP(a_no_input_in_walk, walk_sts.busy, !s_tready)
    `BSA_ASSERT_IMP(a_div_start_idle, div_start, !div_busy)
    `BSA_ASSERT(a_clear_after_report, out_load |=> (r_cnt == '0 && r_odd == '0))
endmodule
`default_nettype wire
